[hw/rtl/mftc_pkg.sv]
// ----------------------------------------------------------------------------
// mftc_pkg
// Shared types, codes and keyword tables for the material file token
// classifier.
// ----------------------------------------------------------------------------
package mftc_pkg;

  // Input and result transfers
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } mftc_in_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] token_length;
    logic       last_of_run;
  } mftc_out_t;

  // Up to two results caused by one input byte
  typedef struct packed {
    logic [1:0] count;
    mftc_out_t  first;
    mftc_out_t  second;
  } mftc_res_t;

  // Length limit
  localparam int MaxTokenLength = 255;
  localparam int LenCap         = (MaxTokenLength < 255) ? MaxTokenLength : 255;

  // Result queue
  localparam int ResDepth = 4;
  localparam int ResPtrW  = $clog2(ResDepth);
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // Token kinds
  localparam logic [4:0] KindUnknown = 5'd0;
  localparam logic [4:0] KindError   = 5'd1;
  localparam logic [4:0] KindEof     = 5'd2;
  localparam logic [4:0] KindIdent   = 5'd3;
  localparam logic [4:0] KindFloat   = 5'd4;
  localparam logic [4:0] KindUint    = 5'd5;
  localparam logic [4:0] KindKw0     = 5'd6;
  localparam logic [4:0] KindNameLo  = 5'd11;
  localparam logic [4:0] KindNameHi  = 5'd16;

  // Characters
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;

  // Keywords, left-justified, eight characters each
  localparam int NumKeywords = 11;
  localparam int KwMaxLen    = 8;
  localparam int KwIdxW      = $clog2(NumKeywords);

  localparam logic [KwMaxLen*8-1:0] KwText [NumKeywords] = '{
    "Ns      ", "Ka      ", "Kd      ", "Ks      ", "d       ",
    "map_Ka  ", "map_Kd  ", "map_Ks  ", 64'h6D61705F42756D70, "map_d   ", "newmtl  "
  };
  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd6, 4'd6, 4'd6, 4'd8, 4'd5, 4'd6
  };

  typedef enum logic [2:0] {
    PhStart, PhMinus, PhInt, PhDot, PhFrac, PhBad, PhBadDot
  } num_phase_e;

  typedef enum logic [1:0] {
    ClsOther, ClsAlpha, ClsDigit, ClsMinus
  } char_class_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic num_phase_e next_phase(input num_phase_e ph, input logic [7:0] c);
    logic dg;
    logic dot;
    dg  = is_digit(c);
    dot = (c == CharDot);
    case (ph)
      PhStart: begin
        if (c == CharMinus) return PhMinus;
        else if (dg)        return PhInt;
        else if (dot)       return PhBadDot;
        else                return PhBad;
      end
      PhMinus: return dg ? PhInt : (dot ? PhBadDot : PhBad);
      PhInt:   return dg ? PhInt : (dot ? PhDot : PhBad);
      PhDot:   return dg ? PhFrac : PhBadDot;
      PhFrac:  return dg ? PhFrac : PhBadDot;
      PhBad:   return dot ? PhBadDot : PhBad;
      default: return PhBadDot;
    endcase
  endfunction

endpackage

[hw/rtl/mftc_lexer.sv]
// ----------------------------------------------------------------------------
// mftc_lexer
// Token state, per-byte keyword and number tracking, and classification of
// the finished token. Produces up to two results for the registered byte.
// ----------------------------------------------------------------------------
module mftc_lexer import mftc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mftc_in_t  item_i,
  input  logic      adv_i,
  output mftc_res_t res_o
);

  logic                   inside_tok_q, inside_tok_d;
  logic                   comment_q,    comment_d;
  logic                   prev_name_q,  prev_name_d;
  logic [NumKeywords-1:0] cand_q,       cand_d;
  num_phase_e             phase_q,      phase_d;
  char_class_e            cls_q,        cls_d;
  logic [7:0]             chars_q,      chars_d;

  logic [7:0]             c;
  logic [NumKeywords-1:0] kw_hit;
  logic [NumKeywords-1:0] kw_match;
  logic [KwIdxW-1:0]      kw_idx;
  logic                   kw_found;
  logic                   dot_seen;
  logic [4:0]             kind;
  logic                   kind_is_name;

  assign c = item_i.in_byte;

  // Keyword bookkeeping: exact-length hits for classification, per-char match
  always_comb begin
    kw_idx   = '0;
    kw_found = 1'b0;
    for (int i = 0; i < NumKeywords; i++) begin
      kw_hit[i]   = cand_q[i] && (chars_q == {4'd0, KwLen[i]});
      kw_match[i] = (chars_q < {4'd0, KwLen[i]}) &&
                    (KwText[i][{~chars_q[2:0], 3'b000} +: 8] == c);
    end
    for (int i = NumKeywords - 1; i >= 0; i--) begin
      if (kw_hit[i]) begin
        kw_idx   = KwIdxW'(i);
        kw_found = 1'b1;
      end
    end
  end

  // Classify the pending token
  always_comb begin
    dot_seen = (phase_q == PhDot) || (phase_q == PhBadDot);
    if (prev_name_q) begin
      kind = KindIdent;
    end else if (cls_q == ClsAlpha) begin
      kind = kw_found ? (KindKw0 + 5'(kw_idx)) : KindError;
    end else if (phase_q == PhFrac) begin
      kind = KindFloat;
    end else if (dot_seen && ((cls_q == ClsMinus) || (cls_q == ClsDigit))) begin
      kind = KindError;
    end else if (cls_q == ClsDigit) begin
      kind = (phase_q == PhInt) ? KindUint : KindError;
    end else begin
      kind = KindUnknown;
    end
    kind_is_name = (kind >= KindNameLo) && (kind <= KindNameHi);
  end

  // Results and next state
  always_comb begin
    res_o        = '0;
    inside_tok_d = inside_tok_q;
    comment_d    = comment_q;
    prev_name_d  = prev_name_q;
    cand_d       = cand_q;
    phase_d      = phase_q;
    cls_d        = cls_q;
    chars_d      = chars_q;

    if (item_i.end_of_stream) begin
      // flush pending token, then end of file
      if (inside_tok_q) begin
        res_o.count  = 2'd2;
        res_o.first  = '{token_kind: kind, token_length: chars_q, last_of_run: 1'b0};
        res_o.second = '{token_kind: KindEof, token_length: 8'd0, last_of_run: 1'b1};
      end else begin
        res_o.count = 2'd1;
        res_o.first = '{token_kind: KindEof, token_length: 8'd0, last_of_run: 1'b1};
      end
      comment_d    = 1'b0;
      prev_name_d  = 1'b0;
      inside_tok_d = 1'b0;
      cand_d       = '1;
      phase_d      = PhStart;
      cls_d        = ClsOther;
      chars_d      = '0;
    end else if (comment_q) begin
      if (c == CharLf) comment_d = 1'b0;
    end else if (is_space(c)) begin
      if (inside_tok_q) begin
        res_o.count  = 2'd1;
        res_o.first  = '{token_kind: kind, token_length: chars_q, last_of_run: 1'b1};
        prev_name_d  = kind_is_name;
        inside_tok_d = 1'b0;
        cand_d       = '1;
        phase_d      = PhStart;
        cls_d        = ClsOther;
        chars_d      = '0;
      end
    end else if (!inside_tok_q && (c == CharHash)) begin
      comment_d = 1'b1;
    end else begin
      if (!inside_tok_q) begin
        inside_tok_d = 1'b1;
        if (is_alpha(c))            cls_d = ClsAlpha;
        else if (is_digit(c))       cls_d = ClsDigit;
        else if (c == CharMinus)    cls_d = ClsMinus;
        else                        cls_d = ClsOther;
      end
      cand_d  = cand_q & kw_match;
      phase_d = next_phase(phase_q, c);
      if (chars_q < 8'(LenCap)) chars_d = chars_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_tok_q <= 1'b0;
      comment_q    <= 1'b0;
      prev_name_q  <= 1'b0;
      cand_q       <= '1;
      phase_q      <= PhStart;
      cls_q        <= ClsOther;
      chars_q      <= '0;
    end else if (adv_i) begin
      inside_tok_q <= inside_tok_d;
      comment_q    <= comment_d;
      prev_name_q  <= prev_name_d;
      cand_q       <= cand_d;
      phase_q      <= phase_d;
      cls_q        <= cls_d;
      chars_q      <= chars_d;
    end
  end

  a_tok_comment_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(inside_tok_q && comment_q))
    else $error("token and comment active together");

  a_len_tracks_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_tok_q == (chars_q != 8'd0))
    else $error("length count out of step with token state");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && item_i.end_of_stream) |=> (!inside_tok_q && !comment_q && !prev_name_q))
    else $error("end of stream left state behind");

endmodule

[hw/rtl/mftc_res_fifo.sv]
// ----------------------------------------------------------------------------
// mftc_res_fifo
// Small result queue: takes zero, one or two results per cycle and offers
// one result per transfer on the output channel.
// ----------------------------------------------------------------------------
module mftc_res_fifo import mftc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mftc_res_t res_i,
  input  logic      push_en_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mftc_out_t out_item_o
);

  mftc_out_t          mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, wr_d, wr_nx;
  logic [ResPtrW-1:0] rd_q, rd_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic [ResCntW-1:0] free;
  logic [ResCntW-1:0] push_n;
  logic               pop;

  assign free        = ResCntW'(ResDepth) - cnt_q;
  assign push_n      = push_en_i ? ResCntW'(res_i.count) : '0;
  assign room_o      = ResCntW'(res_i.count) <= free;
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_nx       = wr_q + ResPtrW'(1);

  always_comb begin
    wr_d  = wr_q + ResPtrW'(push_n);
    rd_d  = pop ? rd_q + ResPtrW'(1) : rd_q;
    cnt_d = cnt_q + push_n - (pop ? ResCntW'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_en_i && (res_i.count != 2'd0)) mem_q[wr_q] <= res_i.first;
    if (push_en_i && (res_i.count == 2'd2)) mem_q[wr_nx] <= res_i.second;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en_i |-> room_o)
    else $error("push without room");

endmodule

[hw/rtl/material_file_token_classifier_core.sv]
// ----------------------------------------------------------------------------
// material_file_token_classifier_core
// Byte-stream lexer for material text: splits tokens on whitespace, skips
// comments, and reports each token's kind and saturated length.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register, then its results
//   enter the result queue, from which they are offered.
// Throughput: one byte per cycle while the 4-entry queue has room for all
//   results of the held byte; end of stream with a pending token makes
//   two results and holds the input only when the queue lacks room.
// Reset: token state, comment flag and queue are cleared; no results pending.
module material_file_token_classifier_core import mftc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mftc_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mftc_out_t out_item_o
);

  // Input register: holds one accepted byte until the lexer consumes it
  logic      in_vld_q, in_vld_d;
  mftc_in_t  in_q;
  logic      in_take;
  logic      consume;
  logic      room;
  mftc_res_t res;

  // Consume the held byte when the queue can take all of its results.
  // Stall only depends on registered state, never on out_stall_i.
  assign consume    = in_vld_q && room;
  assign in_stall_o = in_vld_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)      in_vld_d = 1'b1;
    else if (consume) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload: load on every transfer
  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_item_i;
  end

  // Lexer: advance state as the byte is consumed
  mftc_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .adv_i  (consume),
    .res_o  (res)
  );

  // Result queue: parts the lexer from output back-pressure
  mftc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .push_en_i   (consume),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
